// File: src/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gops_pkg.sv
// Package with constants, types and angle helpers of the GNSS/odometry pose switch.
package gops_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ZW           = (ANGLE_BITS > 16 ? ANGLE_BITS : 16) + 4;
    localparam int CW           = 60;
    localparam int IW           = 5;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam logic [1:0] KIND_FIX  = 2'd0;
    localparam logic [1:0] KIND_GNSS = 2'd1;
    localparam logic [1:0] KIND_ODOM = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    localparam logic [1:0] SRC_GNSS = 2'd0;
    localparam logic [1:0] SRC_FIX  = 2'd1;
    localparam logic [1:0] SRC_DEAD = 2'd2;

    localparam logic [2:0] REG_SPEED_MIN = 3'd0;
    localparam logic [2:0] REG_STEP_MIN  = 3'd1;
    localparam logic [2:0] REG_STEP_MAX  = 3'd2;
    localparam logic [2:0] REG_HEAD_TOL  = 3'd3;
    localparam logic [2:0] REG_ANCHOR    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_DX,
        S_M_DY,
        S_M_LO,
        S_M_HI,
        S_M_CMP,
        S_R_MX,
        S_R_MY,
        S_R_SET,
        S_CORD,
        S_FIN
    } state_t;

    localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
        32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4, 32'h028b0d43, 32'h0145d7e1,
        32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c, 32'h000028be, 32'h0000145f,
        32'h00000a2f, 32'h00000517, 32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
    };

    function automatic logic signed [ZW-1:0] atan_step(input logic [IW-1:0] i);
        logic [32:0] t;
        begin
            t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
            t = t >> (32 - ANGLE_BITS);
            return ZW'(t);
        end
    endfunction

    function automatic logic signed [ZW-1:0] from16(input logic signed [15:0] a);
        logic signed [ZW-1:0] w;
        begin
            w = ZW'(a);
            if (ANGLE_BITS > 16)
                w = w <<< (ANGLE_BITS - 16);
            else if (ANGLE_BITS < 16)
                w = (w + (ZW'(1) <<< (15 - ANGLE_BITS))) >>> (16 - ANGLE_BITS);
            return w;
        end
    endfunction

    function automatic logic [15:0] to16(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] w;
        begin
            w = z;
            if (ANGLE_BITS > 16)
                w = (w + (ZW'(1) <<< (ANGLE_BITS - 17))) >>> (ANGLE_BITS - 16);
            else if (ANGLE_BITS < 16)
                w = w <<< (16 - ANGLE_BITS);
            return w[15:0];
        end
    endfunction

endpackage

// File: src/gnss_odometry_pose_switch_top.sv
// Top level of the GNSS/odometry pose switch with its shared multiplier and CORDIC sequencer.
// Usage:
// Input words (kind, fix_ok, pos_x, pos_y, odom_yaw, speed, turn_rate) arrive on a
// valid/ready channel; fix status, GNSS and odometry words only update state.
// A tick word, once all three sources have been seen, yields one pose word on the
// output valid/ready channel.
// A non-tick word is taken into its registers on acceptance. A tick with fix runs five
// multiplier and compare steps for the displacement window, CORDIC_STEPS vectoring
// iterations and one update step before the pose word; the vectoring is skipped when the
// speed or displacement test fails. A tick without fix runs two gain multiplies, one
// setup step, CORDIC_STEPS rotation iterations and one update step. The one shared
// multiplier and the one CORDIC add/shift stage set this sequence; the input is not
// ready while a tick is in progress.
// The result stays in the output register until taken; a new word may be accepted
// meanwhile, but a following tick holds in its update cycle until the output is free.
// Reset clears the pose and all sensor history; configuration registers return to their
// defaults. Configuration is written through cfg_we, cfg_index and cfg_data while idle;
// the user must keep to that, since the block itself does not enforce it.
module gnss_odometry_pose_switch_top
    import gops_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic               fix_ok,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] odom_yaw,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] turn_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [15:0] out_heading,
    output logic signed [31:0] out_speed,
    output logic signed [31:0] out_turn_rate,
    output logic [1:0]         heading_source
);

`include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [30:0] speed_min_reg, step_min_reg, step_max_reg;
    logic [14:0] head_tol_reg;
    logic [7:0]  anchor_period_reg;

    logic [31:0] pose_x_reg, pose_y_reg, gnss_x_reg, gnss_y_reg, anchor_x_reg, anchor_y_reg;
    logic [31:0] oprev_x_reg, oprev_y_reg, ostep_x_reg, ostep_y_reg;
    logic [31:0] speed_reg, turn_rate_reg;
    logic [15:0] heading_reg, oprev_yaw_reg, ostep_yaw_reg, odom_heading_reg;
    logic [15:0] cand_reg, prev_cand_reg, frame_offset_reg;
    logic        fix_good_reg, seen_fix_reg, seen_gnss_reg, seen_odom_reg, was_gnss_reg;
    logic [7:0]  anchor_cnt_reg;

    logic signed [31:0] dx_reg, dy_reg;
    logic [30:0]        dxm_reg, dym_reg;
    logic               ok_reg, fix_path_reg;
    logic [63:0]        acc_reg, lo_reg;
    logic signed [33:0] vx_reg, vy_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] mul_a, mul_b;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [IW-1:0]        iter_reg;

    logic [31:0] ox_reg, oy_reg, ospd_reg, otr_reg;
    logic [15:0] ohead_reg;
    logic [1:0]  osrc_reg;
    logic        ovalid_reg;

    logic accept, seen_all, out_free, dir;
    logic signed [32:0] dx_w, dy_w, dxm_w, dym_w;
    logic signed [32:0] spd_w;
    logic [15:0] fo_w, ang_w, cand_w;
    logic signed [15:0] a_w;
    logic flip_w;
    logic signed [CW-1:0] xs_w, ys_w, vix_w, viy_w;
    logic signed [16:0] pm_w, cm_w, diff_w;
    logic signed [CW-1:0] rx_w, ry_w;
    logic [7:0] cnt1_w;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign seen_all = seen_fix_reg && seen_gnss_reg && seen_odom_reg;
    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        dx_w  = {gnss_x_reg[31], gnss_x_reg} - {anchor_x_reg[31], anchor_x_reg};
        dy_w  = {gnss_y_reg[31], gnss_y_reg} - {anchor_y_reg[31], anchor_y_reg};
        dxm_w = dx_w[32] ? -dx_w : dx_w;
        dym_w = dy_w[32] ? -dy_w : dy_w;
        spd_w = {speed_reg[31], speed_reg};
        fo_w  = was_gnss_reg ? (heading_reg - odom_heading_reg) : frame_offset_reg;
        a_w   = $signed(fo_w);
        flip_w = (a_w > 16'sd16384) || (a_w < -16'sd16384);
        ang_w = flip_w ? (fo_w - 16'h8000) : fo_w;
        xs_w  = cx_reg >>> iter_reg;
        ys_w  = cy_reg >>> iter_reg;
        dir   = fix_path_reg ? (cy_reg > 0) : (cz_reg >= 0);
        vix_w = CW'(dx_reg) <<< 24;
        viy_w = CW'(dy_reg) <<< 24;
        cand_w = ok_reg ? to16(cz_reg) : cand_reg;
        pm_w  = prev_cand_reg[15] ? -{prev_cand_reg[15], prev_cand_reg}
                                  : {1'b0, prev_cand_reg};
        cm_w  = cand_w[15] ? -{cand_w[15], cand_w} : {1'b0, cand_w};
        diff_w = (pm_w >= cm_w) ? (pm_w - cm_w) : (cm_w - pm_w);
        rx_w  = (cx_reg + (CW'(1) <<< 19)) >>> 20;
        ry_w  = (cy_reg + (CW'(1) <<< 19)) >>> 20;
        cnt1_w = anchor_cnt_reg + 8'd1;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M_DX:
            begin
                mul_a = {3'b0, dxm_reg};
                mul_b = {3'b0, dxm_reg};
            end
            S_M_DY:
            begin
                mul_a = {3'b0, dym_reg};
                mul_b = {3'b0, dym_reg};
            end
            S_M_LO:
            begin
                mul_a = {3'b0, step_min_reg};
                mul_b = {3'b0, step_min_reg};
            end
            S_M_HI:
            begin
                mul_a = {3'b0, step_max_reg};
                mul_b = {3'b0, step_max_reg};
            end
            S_R_MX:
            begin
                mul_a = vx_reg;
                mul_b = {4'b0, GAIN_Q30};
            end
            S_R_MY:
            begin
                mul_a = vy_reg;
                mul_b = {4'b0, GAIN_Q30};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && kind == KIND_TICK && seen_all)
                    state_next = fix_good_reg ? S_M_DX : S_R_MX;
            S_M_DX:  state_next = S_M_DY;
            S_M_DY:  state_next = S_M_LO;
            S_M_LO:  state_next = S_M_HI;
            S_M_HI:  state_next = S_M_CMP;
            S_M_CMP:
                if (ok_reg && acc_reg > lo_reg && acc_reg < 64'(prod_reg))
                    state_next = S_CORD;
                else
                    state_next = S_FIN;
            S_R_MX:  state_next = S_R_MY;
            S_R_MY:  state_next = S_R_SET;
            S_R_SET: state_next = S_CORD;
            S_CORD:
                if (iter_reg == IW'(CORDIC_STEPS - 1))
                    state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_min_reg     <= 31'd13107;
            step_min_reg      <= 31'd1966;
            step_max_reg      <= 31'd196608;
            head_tol_reg      <= 15'd3277;
            anchor_period_reg <= 8'd20;
            pose_x_reg <= '0; pose_y_reg <= '0; gnss_x_reg <= '0; gnss_y_reg <= '0;
            anchor_x_reg <= '0; anchor_y_reg <= '0;
            oprev_x_reg <= '0; oprev_y_reg <= '0; ostep_x_reg <= '0; ostep_y_reg <= '0;
            speed_reg <= '0; turn_rate_reg <= '0;
            heading_reg <= '0; oprev_yaw_reg <= '0; ostep_yaw_reg <= '0;
            odom_heading_reg <= '0;
            cand_reg <= '0; prev_cand_reg <= '0; frame_offset_reg <= '0;
            fix_good_reg <= 1'b1; was_gnss_reg <= 1'b1;
            seen_fix_reg <= 1'b0; seen_gnss_reg <= 1'b0; seen_odom_reg <= 1'b0;
            anchor_cnt_reg <= '0;
            ovalid_reg <= 1'b0;
            ok_reg <= 1'b0; fix_path_reg <= 1'b0; iter_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SPEED_MIN: speed_min_reg     <= cfg_data;
                    REG_STEP_MIN:  step_min_reg      <= cfg_data;
                    REG_STEP_MAX:  step_max_reg      <= cfg_data;
                    REG_HEAD_TOL:  head_tol_reg      <= cfg_data[14:0];
                    REG_ANCHOR:    anchor_period_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && out_ready && state_reg != S_FIN)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        case (kind)
                            KIND_FIX:
                            begin
                                fix_good_reg <= fix_ok;
                                seen_fix_reg <= 1'b1;
                            end
                            KIND_GNSS:
                            begin
                                gnss_x_reg    <= pos_x;
                                gnss_y_reg    <= pos_y;
                                seen_gnss_reg <= 1'b1;
                            end
                            KIND_ODOM:
                            begin
                                ostep_x_reg   <= pos_x - oprev_x_reg;
                                ostep_y_reg   <= pos_y - oprev_y_reg;
                                ostep_yaw_reg <= odom_yaw - oprev_yaw_reg;
                                oprev_x_reg   <= pos_x;
                                oprev_y_reg   <= pos_y;
                                oprev_yaw_reg <= odom_yaw;
                                odom_heading_reg <= odom_yaw;
                                speed_reg     <= speed;
                                turn_rate_reg <= turn_rate;
                                seen_odom_reg <= 1'b1;
                            end
                            default:
                                if (seen_all)
                                begin
                                    iter_reg     <= '0;
                                    fix_path_reg <= fix_good_reg;
                                    if (fix_good_reg)
                                    begin
                                        pose_x_reg <= gnss_x_reg;
                                        pose_y_reg <= gnss_y_reg;
                                        dx_reg  <= dx_w[31:0];
                                        dy_reg  <= dy_w[31:0];
                                        dxm_reg <= dxm_w[30:0];
                                        dym_reg <= dym_w[30:0];
                                        ok_reg  <= (spd_w > $signed({2'b0, speed_min_reg}))
                                                   && !dxm_w[32] && !dxm_w[31]
                                                   && !dym_w[32] && !dym_w[31];
                                    end
                                    else
                                    begin
                                        frame_offset_reg <= fo_w;
                                        vx_reg <= flip_w ? -34'(signed'(ostep_x_reg))
                                                         : 34'(signed'(ostep_x_reg));
                                        vy_reg <= flip_w ? -34'(signed'(ostep_y_reg))
                                                         : 34'(signed'(ostep_y_reg));
                                        cz_reg <= from16(signed'(ang_w));
                                    end
                                end
                        endcase
                    end
                S_M_DY:  acc_reg <= 64'(prod_reg);
                S_M_LO:  acc_reg <= acc_reg + 64'(prod_reg);
                S_M_HI:  lo_reg  <= 64'(prod_reg);
                S_M_CMP:
                begin
                    ok_reg <= ok_reg && acc_reg > lo_reg && acc_reg < 64'(prod_reg);
                    if (dx_reg < 0)
                    begin
                        cx_reg <= -vix_w;
                        cy_reg <= -viy_w;
                        cz_reg <= ZW'(1) <<< (ANGLE_BITS - 1);
                    end
                    else
                    begin
                        cx_reg <= vix_w;
                        cy_reg <= viy_w;
                        cz_reg <= '0;
                    end
                end
                S_R_MY:  cx_reg <= CW'(prod_reg >>> 10);
                S_R_SET: cy_reg <= CW'(prod_reg >>> 10);
                S_CORD:
                begin
                    iter_reg <= iter_reg + IW'(1);
                    if (fix_path_reg ? dir : !dir)
                    begin
                        cx_reg <= cx_reg + ys_w;
                        cy_reg <= cy_reg - xs_w;
                        cz_reg <= cz_reg + atan_step(iter_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys_w;
                        cy_reg <= cy_reg + xs_w;
                        cz_reg <= cz_reg - atan_step(iter_reg);
                    end
                end
                S_FIN:
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        ospd_reg   <= speed_reg;
                        otr_reg    <= turn_rate_reg;
                        if (fix_path_reg)
                        begin
                            ox_reg <= pose_x_reg;
                            oy_reg <= pose_y_reg;
                            if (ok_reg)
                                cand_reg <= cand_w;
                            prev_cand_reg <= cand_w;
                            if (ok_reg && diff_w <= $signed({2'b0, head_tol_reg}))
                            begin
                                heading_reg <= cand_w;
                                ohead_reg   <= cand_w;
                                osrc_reg    <= SRC_GNSS;
                            end
                            else
                            begin
                                heading_reg <= heading_reg + ostep_yaw_reg;
                                ohead_reg   <= heading_reg + ostep_yaw_reg;
                                osrc_reg    <= SRC_FIX;
                            end
                            if (anchor_cnt_reg == 8'd0)
                            begin
                                anchor_x_reg <= pose_x_reg;
                                anchor_y_reg <= pose_y_reg;
                            end
                            anchor_cnt_reg <= (cnt1_w >= anchor_period_reg) ? 8'd0 : cnt1_w;
                            was_gnss_reg <= 1'b1;
                        end
                        else
                        begin
                            pose_x_reg  <= pose_x_reg + rx_w[31:0];
                            pose_y_reg  <= pose_y_reg + ry_w[31:0];
                            ox_reg      <= pose_x_reg + rx_w[31:0];
                            oy_reg      <= pose_y_reg + ry_w[31:0];
                            heading_reg <= heading_reg + ostep_yaw_reg;
                            ohead_reg   <= heading_reg + ostep_yaw_reg;
                            osrc_reg    <= SRC_DEAD;
                            was_gnss_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    assign out_valid      = ovalid_reg;
    assign out_x          = ox_reg;
    assign out_y          = oy_reg;
    assign out_heading    = ohead_reg;
    assign out_speed      = ospd_reg;
    assign out_turn_rate  = otr_reg;
    assign heading_source = osrc_reg;

    `ASSERT_IMPL(a_iter_range, clk, rst_n, state_reg == S_CORD,
        iter_reg < IW'(CORDIC_STEPS), "CORDIC iteration count out of range")
    `ASSERT_IMPL(a_src_code, clk, rst_n, out_valid,
        heading_source != 2'd3, "Invalid heading source on output")
    `ASSERT_IMPL(a_rise_from_fin, clk, rst_n, $rose(ovalid_reg),
        $past(state_reg) == S_FIN, "Output word raised outside the update cycle")

endmodule

// File: bench/gnss_odometry_pose_switch_top_tb.sv
// Self-checking testbench of the GNSS/odometry pose switch with a pose predictor scoreboard.
`timescale 1ns / 100ps

module gnss_odometry_pose_switch_top_tb;
    import gops_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [1:0]  kind;
        logic        fix_ok;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] yaw;
        logic [31:0] spd;
        logic [31:0] tr;
    } sensor_word_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [31:0] spd;
        logic [31:0] tr;
        logic [1:0]  src;
    } pose_word_t;

    class pose_scoreboard;
        pose_word_t pending_poses[$];
        int mismatches;
        logic [30:0] speed_min, step_min, step_max;
        logic [14:0] tolerance;
        logic [7:0] period;
        logic [31:0] pose_x, pose_y, gnss_x, gnss_y, anchor_x, anchor_y;
        logic [31:0] prev_x, prev_y, step_x, step_y, speed_last, rate_last;
        logic [15:0] pose_h, prev_yaw, step_yaw, odo_h, cand, prev_cand, frame;
        logic fix_good, seen_fix, seen_gnss, seen_odom, was_gnss;
        logic [7:0] anchor_cnt;

        function new();
            speed_min = 13107; step_min = 1966; step_max = 196608;
            tolerance = 3277; period = 20;
            pose_x = 0; pose_y = 0; gnss_x = 0; gnss_y = 0; anchor_x = 0; anchor_y = 0;
            prev_x = 0; prev_y = 0; step_x = 0; step_y = 0; speed_last = 0; rate_last = 0;
            pose_h = 0; prev_yaw = 0; step_yaw = 0; odo_h = 0; cand = 0; prev_cand = 0;
            frame = 0; fix_good = 1; was_gnss = 1;
            seen_fix = 0; seen_gnss = 0; seen_odom = 0; anchor_cnt = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [30:0] val);
            case (idx)
                REG_SPEED_MIN: speed_min = val;
                REG_STEP_MIN:  step_min = val;
                REG_STEP_MAX:  step_max = val;
                REG_HEAD_TOL:  tolerance = val[14:0];
                REG_ANCHOR:    period = val[7:0];
                default: ;
            endcase
        endfunction

        function longint arc_step(int i);
            longint t;
            t = ATAN_TURN32[i];
            return (t + 32768) >> 16;
        endfunction

        function logic [15:0] bearing(longint dx, longint dy);
            longint x, y, z, xs, ys;
            x = dx * 16777216;
            y = dy * 16777216;
            z = 0;
            if (x < 0)
            begin
                x = -x; y = -y; z = 32768;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i; ys = y >>> i;
                if (y > 0)
                begin
                    x += ys; y -= xs; z += arc_step(i);
                end
                else
                begin
                    x -= ys; y += xs; z -= arc_step(i);
                end
            end
            return z[15:0];
        endfunction

        function void turn_step(longint vx, longint vy, logic [15:0] ang,
                                output longint ox, output longint oy);
            longint a, x, y, z, xs, ys;
            logic [15:0] t;
            a = longint'($signed(ang));
            if (a > 16384 || a < -16384)
            begin
                vx = -vx; vy = -vy;
                t = a[15:0] - 16'h8000;
                a = longint'($signed(t));
            end
            z = a;
            x = (vx * longint'(GAIN_Q30)) >>> 10;
            y = (vy * longint'(GAIN_Q30)) >>> 10;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i; ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= arc_step(i);
                end
                else
                begin
                    x += ys; y -= xs; z += arc_step(i);
                end
            end
            ox = (x + (longint'(1) << 19)) >>> 20;
            oy = (y + (longint'(1) << 19)) >>> 20;
        endfunction

        function void note_input(sensor_word_t w);
            longint dx, dy, tx, ty, diff, pc, cc;
            longint unsigned d2, lo, hi;
            logic ok;
            logic [1:0] src;
            pose_word_t p;
            case (w.kind)
                KIND_FIX:
                begin
                    fix_good = w.fix_ok; seen_fix = 1;
                    return;
                end
                KIND_GNSS:
                begin
                    gnss_x = w.px; gnss_y = w.py; seen_gnss = 1;
                    return;
                end
                KIND_ODOM:
                begin
                    step_x = w.px - prev_x; step_y = w.py - prev_y;
                    step_yaw = w.yaw - prev_yaw;
                    prev_x = w.px; prev_y = w.py; prev_yaw = w.yaw; odo_h = w.yaw;
                    speed_last = w.spd; rate_last = w.tr; seen_odom = 1;
                    return;
                end
                default: ;
            endcase
            if (!(seen_fix && seen_gnss && seen_odom))
                return;
            if (fix_good)
            begin
                pose_x = gnss_x; pose_y = gnss_y;
                dx = longint'($signed(pose_x)) - longint'($signed(anchor_x));
                dy = longint'($signed(pose_y)) - longint'($signed(anchor_y));
                ok = longint'($signed(speed_last)) > longint'(speed_min);
                if (dx >= (longint'(1) <<< 31) || dx <= -(longint'(1) <<< 31) ||
                    dy >= (longint'(1) <<< 31) || dy <= -(longint'(1) <<< 31))
                    ok = 0;
                if (ok)
                begin
                    d2 = longint'(dx * dx) + longint'(dy * dy);
                    lo = longint'(step_min) * longint'(step_min);
                    hi = longint'(step_max) * longint'(step_max);
                    ok = d2 > lo && d2 < hi;
                end
                src = SRC_FIX;
                if (ok)
                begin
                    cand = bearing(dx, dy);
                    pc = longint'($signed(prev_cand));
                    cc = longint'($signed(cand));
                    if (pc < 0) pc = -pc;
                    if (cc < 0) cc = -cc;
                    diff = pc - cc;
                    if (diff < 0) diff = -diff;
                    if (diff <= longint'(tolerance))
                    begin
                        pose_h = cand; src = SRC_GNSS;
                    end
                end
                if (src == SRC_FIX)
                    pose_h = pose_h + step_yaw;
                if (anchor_cnt == 0)
                begin
                    anchor_x = pose_x; anchor_y = pose_y;
                end
                prev_cand = cand;
                anchor_cnt = anchor_cnt + 8'd1;
                if (anchor_cnt >= period)
                    anchor_cnt = 0;
                was_gnss = 1;
            end
            else
            begin
                if (was_gnss)
                    frame = pose_h - odo_h;
                turn_step(longint'($signed(step_x)), longint'($signed(step_y)), frame, tx, ty);
                pose_x = pose_x + tx[31:0];
                pose_y = pose_y + ty[31:0];
                pose_h = pose_h + step_yaw;
                was_gnss = 0;
                src = SRC_DEAD;
            end
            p.x = pose_x; p.y = pose_y; p.heading = pose_h;
            p.spd = speed_last; p.tr = rate_last; p.src = src;
            pending_poses.push_back(p);
        endfunction

        function void check_result(pose_word_t a);
            pose_word_t e;
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose word x=%h y=%h h=%h", a.x, a.y, a.heading);
                return;
            end
            e = pending_poses.pop_front();
            if (a.x !== e.x || a.y !== e.y || a.heading !== e.heading ||
                a.spd !== e.spd || a.tr !== e.tr || a.src !== e.src)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pose mismatch: expected %h %h %h %h %h %0d, got %h %h %h %h %h %0d",
                             e.x, e.y, e.heading, e.spd, e.tr, e.src,
                             a.x, a.y, a.heading, a.spd, a.tr, a.src);
            end
        endfunction
    endclass

    logic clk, rst_n, cfg_we, in_valid, in_ready, fix_ok, out_valid, out_ready;
    logic [2:0] cfg_index;
    logic [30:0] cfg_data;
    logic [1:0] kind, heading_source;
    logic signed [31:0] pos_x, pos_y, speed, turn_rate, out_x, out_y, out_speed, out_turn_rate;
    logic signed [15:0] odom_yaw, out_heading;

    pose_scoreboard sb;
    int send_idle_pct, recv_stall_pct, cycles;
    logic [31:0] track_gx, track_gy, track_ox, track_oy;
    logic [15:0] track_yaw;

    gnss_odometry_pose_switch_top dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pose_word_t a;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            a.x = out_x; a.y = out_y; a.heading = out_heading;
            a.spd = out_speed; a.tr = out_turn_rate; a.src = heading_source;
            sb.check_result(a);
        end
    end

    task automatic send_word(logic [1:0] k, logic f, logic [31:0] x, logic [31:0] y,
                             logic [15:0] yw, logic [31:0] s, logic [31:0] r);
        sensor_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= k; fix_ok <= f; pos_x <= x; pos_y <= y;
        odom_yaw <= yw; speed <= s; turn_rate <= r;
        do
            @(posedge clk);
        while (!in_ready);
        w.kind = k; w.fix_ok = f; w.px = x; w.py = y; w.yaw = yw; w.spd = s; w.tr = r;
        sb.note_input(w);
    endtask

    task automatic drain_and_configure(logic [30:0] smin, logic [30:0] stmin,
                                       logic [30:0] stmax, logic [30:0] tol, logic [30:0] per);
        logic [30:0] vals [5];
        in_valid <= 0;
        while (sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        vals = '{smin, stmin, stmax, tol, per};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(3'(i), vals[i]);
        end
        cfg_we <= 0;
    endtask

    task automatic random_burst();
        logic [31:0] d;
        if ($urandom_range(99) < 15)
        begin
            send_word(2'($urandom), 1'($urandom), $urandom, $urandom, 16'($urandom),
                      $urandom, $urandom);
            return;
        end
        if ($urandom_range(99) < 12)
            send_word(KIND_FIX, $urandom_range(99) < 70, $urandom, $urandom, 16'($urandom),
                      $urandom, $urandom);
        if ($urandom_range(99) < 80)
        begin
            d = $urandom_range(262144);
            track_gx = track_gx + d - 131072;
            d = $urandom_range(262144);
            track_gy = track_gy + d - 131072;
            send_word(KIND_GNSS, 1'($urandom), track_gx, track_gy, 16'($urandom),
                      $urandom, $urandom);
        end
        if ($urandom_range(99) < 80)
        begin
            d = $urandom_range(131072);
            track_ox = track_ox + d - 65536;
            d = $urandom_range(131072);
            track_oy = track_oy + d - 65536;
            track_yaw = track_yaw + 16'($urandom_range(4000)) - 16'd2000;
            send_word(KIND_ODOM, 1'($urandom), track_ox, track_oy, track_yaw,
                      $urandom_range(200000), $urandom);
        end
        send_word(KIND_TICK, 1'($urandom), $urandom, $urandom, 16'($urandom),
                  $urandom, $urandom);
    endtask

    initial
    begin
        int sent;
        sb = new();
        cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        track_gx = 0; track_gy = 0; track_ox = 0; track_oy = 0; track_yaw = 0;
        rst_n <= 0; cfg_we <= 0; cfg_index <= 0; cfg_data <= 0;
        in_valid <= 0; kind <= 0; fix_ok <= 0; pos_x <= 0; pos_y <= 0;
        odom_yaw <= 0; speed <= 0; turn_rate <= 0; out_ready <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        drain_and_configure(13107, 1966, 196608, 3277, 20);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_FIX, 1, 0, 0, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_GNSS, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_word(KIND_ODOM, 0, 32'h80000000, 32'h7fffffff, 16'h8000,
                  32'h7fffffff, 32'h80000000);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_GNSS, 1, 32'h80000000, 32'h7fffffff, 16'hffff, 0, 0);
        send_word(KIND_TICK, 1, 0, 0, 0, 0, 0);
        send_word(KIND_GNSS, 0, 32'h00010000, 32'h00008000, 0, 0, 0);
        send_word(KIND_ODOM, 0, 32'h00010000, 0, 16'h7fff, 32'h00020000, 32'hffffffff);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_GNSS, 0, 32'h00018000, 32'h00010000, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_FIX, 0, 0, 0, 0, 0, 0);
        send_word(KIND_ODOM, 0, 32'h00030000, 32'hffff0000, 16'h9000, 32'h80000000, 0);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_ODOM, 0, 32'h7fff0000, 32'h80010000, 16'h7000, 0, 32'h7fffffff);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);
        send_word(KIND_FIX, 1, 0, 0, 0, 0, 0);
        send_word(KIND_TICK, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: drain_and_configure(13107, 1966, 196608, 3277, 20);
                1: drain_and_configure(0, 0, 31'h7fffffff, 32767, 1);
                2: drain_and_configure(31'h7fffffff, 31'h7fffffff, 0, 0, 255);
                default: drain_and_configure(1000, 500, 150000, 1500, 3);
            endcase
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            sent = 0;
            while (sent < 160)
            begin
                random_burst();
                sent++;
            end
        end
        drain_and_configure(13107, 1966, 196608, 3277, 20);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: gnss_odometry_pose_switch_top.f
+incdir+src
src/gops_pkg.sv
src/gnss_odometry_pose_switch_top.sv
bench/gnss_odometry_pose_switch_top_tb.sv
